### hdl/bspe_pkg.sv
// ----------------------------------------------------------------------------
// B-spline point evaluator package
// Shared types, constants and controller/datapath command structs.
// ----------------------------------------------------------------------------
package bspe_pkg;

   localparam int MAX_KNOTS  = 32;
   localparam int MAX_DEGREE = 7;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_W      = $clog2(MAX_KNOTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int DEG_W      = 3;
   localparam int NCFG_W     = 6;

   localparam logic [1:0] KIND_KNOT  = 2'd0;
   localparam logic [1:0] KIND_COEFF = 2'd1;
   localparam logic [1:0] KIND_EVAL  = 2'd2;

   localparam logic REG_DEGREE = 1'b0;
   localparam logic REG_KNOTS  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_B0_RD,
      ST_B0_WAIT,
      ST_B0_HOLD,
      ST_B0_CMP,
      ST_D_RD0,
      ST_D_WAIT0,
      ST_D_RD1,
      ST_D_WAIT1,
      ST_D_LATCH,
      ST_T0_MUL,
      ST_T0_DIV,
      ST_T0_WAIT,
      ST_T1_MUL,
      ST_T1_DIV,
      ST_T1_WAIT,
      ST_D_WR,
      ST_S_RD,
      ST_S_WAIT,
      ST_S_MUL,
      ST_S_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             eval_start;
      logic             knot_rd;
      logic [IDX_W-1:0] knot_addr;
      logic [1:0]       knot_dst;
      logic             basis_rd;
      logic [IDX_W-1:0] basis_addr;
      logic             basis_dst;
      logic             coeff_rd;
      logic [IDX_W-1:0] coeff_addr;
      logic             b0_write;
      logic             b0_closed;
      logic [IDX_W-1:0] wr_addr;
      logic             term_mul;
      logic             term_sel;
      logic             div_start;
      logic             div_take;
      logic             basis_wr;
      logic             sum_mul;
      logic             sum_acc;
      logic             sum_clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

### hdl/bspe_divider.sv
// ----------------------------------------------------------------------------
// Signed restoring divider
// 65-bit dividend by 34-bit divisor, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module bspe_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [64:0] dividend,
   input  logic signed [33:0] divisor,
   output logic               done,
   output logic signed [64:0] quotient
);

   logic [64:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [33:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff, q_ff[64]} - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend[64] ? 65'(-dividend) : dividend;
         d_in    = divisor[33] ? 34'(-divisor) : divisor;
         neg_in  = dividend[64] ^ divisor[33];
         r_in    = '0;
         cnt_in  = 7'd65;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[34]) begin
            r_in = trial[33:0];
            q_in = {q_ff[63:0], 1'b1};
         end else begin
            r_in = {r_ff[32:0], q_ff[64]};
            q_in = {q_ff[63:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 65'(-$signed(q_ff)) : $signed(q_ff);

endmodule

### hdl/bspe_datapath.sv
// ----------------------------------------------------------------------------
// B-spline evaluator datapath
// Knot, coefficient and basis memories, term multiplier, divider, accumulator.
// ----------------------------------------------------------------------------
module bspe_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [1:0]                    wr_kind,
   input  logic [bspe_pkg::IDX_W-1:0]    wr_slot,
   input  logic signed [31:0]            wr_value,
   input  bspe_pkg::cmd_type             cmd,
   output bspe_pkg::stat_type            stat,
   output logic signed [31:0]            result
);

   logic signed [31:0] knot_mem  [bspe_pkg::MAX_KNOTS];
   logic signed [31:0] coeff_mem [bspe_pkg::MAX_KNOTS];
   logic signed [31:0] basis_mem [bspe_pkg::MAX_KNOTS];

   logic signed [31:0] knot_rd_ff, coeff_rd_ff, basis_rd_ff;
   logic signed [31:0] x_ff, k0_ff, ka_ff, kb_ff, kc_ff, kd_ff;
   logic signed [31:0] ba_ff, bb_ff;
   logic [1:0]         kdst_ff;
   logic               bdst_ff;
   logic signed [64:0] prod_ff;
   logic signed [33:0] den_ff;
   logic               den_nz_ff;
   logic signed [32:0] b_sum_ff, b_sum_in;
   logic signed [63:0] sprod_ff;
   logic signed [47:0] acc_ff;

   logic               div_done;
   logic signed [64:0] quot;
   logic signed [33:0] num, den;
   logic signed [31:0] bsel;
   logic signed [31:0] qsat, bsat, basis_wdata;
   logic               in_span;

   always_ff @(posedge clock) begin
      if (wr_en && wr_kind == bspe_pkg::KIND_KNOT) begin
         knot_mem[wr_slot] <= wr_value;
      end
      if (wr_en && wr_kind == bspe_pkg::KIND_COEFF) begin
         coeff_mem[wr_slot] <= wr_value;
      end
      if (cmd.knot_rd) begin
         knot_rd_ff <= knot_mem[cmd.knot_addr];
      end
      if (cmd.coeff_rd) begin
         coeff_rd_ff <= coeff_mem[cmd.coeff_addr];
      end
      if (cmd.basis_rd) begin
         basis_rd_ff <= basis_mem[cmd.basis_addr];
      end
      if (cmd.b0_write || cmd.basis_wr) begin
         basis_mem[cmd.wr_addr] <= basis_wdata;
      end
   end

   // knot_dst: 0 -> a, 1 -> b, 2 -> c, 3 -> d; pairing handled by controller sequence
   always_ff @(posedge clock) begin
      kdst_ff <= cmd.knot_dst;
      bdst_ff <= cmd.basis_dst;
      if (cmd.eval_start) begin
         x_ff <= wr_value;
      end
      if (cmd.knot_rd && cmd.knot_addr == '0 && cmd.knot_dst == 2'd0) begin
         k0_ff <= knot_mem[0];
      end
   end

   // Latch the read data register into its destination register, per destination
   logic kv_ff, bv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         kv_ff <= 1'b0;
         bv_ff <= 1'b0;
      end else begin
         kv_ff <= cmd.knot_rd;
         bv_ff <= cmd.basis_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (kv_ff) begin
         unique case (kdst_ff)
            2'd0:    ka_ff <= knot_rd_ff;
            2'd1:    kb_ff <= knot_rd_ff;
            2'd2:    kc_ff <= knot_rd_ff;
            default: kd_ff <= knot_rd_ff;
         endcase
      end
      if (bv_ff) begin
         if (bdst_ff) begin
            bb_ff <= basis_rd_ff;
         end else begin
            ba_ff <= basis_rd_ff;
         end
      end
   end

   // Degree 0: ka = knot[i], kb = knot[i+1]
   always_comb begin
      in_span = (x_ff <= kb_ff) &&
                ((cmd.b0_closed && k0_ff == ka_ff) ? (x_ff >= ka_ff) : (x_ff > ka_ff));
   end

   // Degree d: ka = knot[i], kb = knot[i+d], kc = knot[i+1], kd = knot[i+d+1]
   always_comb begin
      if (!cmd.term_sel) begin
         num  = 34'(x_ff) - 34'(ka_ff);
         den  = 34'(kb_ff) - 34'(ka_ff);
         bsel = ba_ff;
      end else begin
         num  = 34'(kd_ff) - 34'(x_ff);
         den  = 34'(kd_ff) - 34'(kc_ff);
         bsel = bb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.term_mul) begin
         prod_ff   <= 65'(num * 66'(bsel));
         den_ff    <= den;
         den_nz_ff <= (den != '0);
      end
   end

   bspe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (den_nz_ff ? den_ff : 34'sd1),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      if (quot > 65'sd2147483647) begin
         qsat = 32'sh7fffffff;
      end else if (quot < -65'sd2147483648) begin
         qsat = 32'sh80000000;
      end else begin
         qsat = quot[31:0];
      end
      b_sum_in = b_sum_ff;
      if (cmd.term_mul && !cmd.term_sel) begin
         b_sum_in = '0;
      end else if (cmd.div_take && den_nz_ff) begin
         b_sum_in = b_sum_ff + 33'(qsat);
      end
      if (b_sum_ff > 33'sd2147483647) begin
         bsat = 32'sh7fffffff;
      end else if (b_sum_ff < -33'sd2147483648) begin
         bsat = 32'sh80000000;
      end else begin
         bsat = b_sum_ff[31:0];
      end
      if (cmd.b0_write) begin
         basis_wdata = in_span ? 32'(1 << bspe_pkg::FRAC_BITS) : '0;
      end else begin
         basis_wdata = bsat;
      end
   end

   always_ff @(posedge clock) begin
      b_sum_ff <= b_sum_in;
      if (cmd.sum_mul) begin
         sprod_ff <= 64'(coeff_rd_ff * 64'(ba_ff));
      end
      if (cmd.sum_clear) begin
         acc_ff <= '0;
      end else if (cmd.sum_acc) begin
         acc_ff <= acc_ff + 48'(sprod_ff >>> bspe_pkg::FRAC_BITS);
      end
   end

   always_comb begin
      if (acc_ff > 48'sd2147483647) begin
         result = 32'sh7fffffff;
      end else if (acc_ff < -48'sd2147483648) begin
         result = 32'sh80000000;
      end else begin
         result = acc_ff[31:0];
      end
   end

   assign stat.div_done = div_done;

endmodule

### hdl/bspe_controller.sv
// ----------------------------------------------------------------------------
// B-spline evaluator controller
// Sequences degree-0 row, Cox-de Boor updates and the output sum.
// ----------------------------------------------------------------------------
module bspe_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          rsp_free,
   input  logic [bspe_pkg::DEG_W-1:0]    degree,
   input  logic [bspe_pkg::NCFG_W-1:0]   knots,
   input  bspe_pkg::stat_type            stat,
   output bspe_pkg::cmd_type             cmd,
   output logic                          busy,
   output logic                          done
);

   localparam int IW = bspe_pkg::IDX_W;
   localparam int CW = bspe_pkg::CNT_W;

   bspe_pkg::state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] n_ff, n_in;
   logic [3:0]    d_ff, d_in;
   logic [3:0]    deg_ff, deg_in;
   logic [1:0]    sub_ff, sub_in;
   logic [CW+3:0] nlim;

   always_comb begin
      nlim = (CW+4)'(knots) > (CW+4)'(bspe_pkg::MAX_KNOTS) ?
             (CW+4)'(bspe_pkg::MAX_KNOTS) : (CW+4)'(knots);
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      deg_in   = deg_ff;
      sub_in   = sub_ff;
      unique case (state_ff)
         bspe_pkg::ST_IDLE: begin
            if (start) begin
               n_in   = CW'(nlim);
               deg_in = 4'(degree);
               i_in   = '0;
               if (nlim < (CW+4)'(degree) + (CW+4)'(2)) begin
                  state_in = bspe_pkg::ST_DONE;
               end else begin
                  state_in = bspe_pkg::ST_B0_RD;
               end
            end
         end
         bspe_pkg::ST_B0_RD:   state_in = bspe_pkg::ST_B0_WAIT;
         bspe_pkg::ST_B0_WAIT: state_in = bspe_pkg::ST_B0_HOLD;
         bspe_pkg::ST_B0_HOLD: state_in = bspe_pkg::ST_B0_CMP;
         bspe_pkg::ST_B0_CMP: begin
            if (i_ff + CW'(2) >= n_ff) begin
               i_in = '0;
               d_in = 4'd1;
               state_in = (deg_ff == 4'd0) ? bspe_pkg::ST_S_RD : bspe_pkg::ST_D_RD0;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = bspe_pkg::ST_B0_RD;
            end
         end
         bspe_pkg::ST_D_RD0:   state_in = bspe_pkg::ST_D_WAIT0;
         bspe_pkg::ST_D_WAIT0: state_in = bspe_pkg::ST_D_RD1;
         bspe_pkg::ST_D_RD1:   state_in = bspe_pkg::ST_D_WAIT1;
         bspe_pkg::ST_D_WAIT1: state_in = bspe_pkg::ST_D_LATCH;
         bspe_pkg::ST_D_LATCH: begin
            sub_in = sub_ff + 2'd1;
            state_in = (sub_ff == 2'd1) ? bspe_pkg::ST_T0_MUL : bspe_pkg::ST_D_RD0;
         end
         bspe_pkg::ST_T0_MUL:  state_in = bspe_pkg::ST_T0_DIV;
         bspe_pkg::ST_T0_DIV:  state_in = bspe_pkg::ST_T0_WAIT;
         bspe_pkg::ST_T0_WAIT: if (stat.div_done) state_in = bspe_pkg::ST_T1_MUL;
         bspe_pkg::ST_T1_MUL:  state_in = bspe_pkg::ST_T1_DIV;
         bspe_pkg::ST_T1_DIV:  state_in = bspe_pkg::ST_T1_WAIT;
         bspe_pkg::ST_T1_WAIT: if (stat.div_done) state_in = bspe_pkg::ST_D_WR;
         bspe_pkg::ST_D_WR: begin
            sub_in = '0;
            if ((CW+4)'(i_ff) + (CW+4)'(d_ff) + (CW+4)'(2) >= (CW+4)'(n_ff)) begin
               i_in = '0;
               if (d_ff == deg_ff) begin
                  state_in = bspe_pkg::ST_S_RD;
               end else begin
                  d_in = d_ff + 4'd1;
                  state_in = bspe_pkg::ST_D_RD0;
               end
            end else begin
               i_in = i_ff + CW'(1);
               state_in = bspe_pkg::ST_D_RD0;
            end
         end
         bspe_pkg::ST_S_RD:   state_in = bspe_pkg::ST_S_WAIT;
         bspe_pkg::ST_S_WAIT: state_in = bspe_pkg::ST_S_MUL;
         bspe_pkg::ST_S_MUL:  state_in = bspe_pkg::ST_S_ACC;
         bspe_pkg::ST_S_ACC: begin
            if ((CW+4)'(i_ff) + (CW+4)'(deg_ff) + (CW+4)'(2) >= (CW+4)'(n_ff)) begin
               state_in = bspe_pkg::ST_DONE;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = bspe_pkg::ST_S_RD;
            end
         end
         bspe_pkg::ST_DONE: state_in = rsp_free ? bspe_pkg::ST_IDLE : bspe_pkg::ST_DONE;
         default:           state_in = bspe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.wr_addr = IW'(i_ff);
      unique case (state_ff)
         bspe_pkg::ST_IDLE: begin
            cmd.eval_start = start;
            cmd.sum_clear  = 1'b1;
         end
         bspe_pkg::ST_B0_RD: begin
            cmd.knot_rd   = 1'b1;
            cmd.knot_addr = IW'(i_ff);
            cmd.knot_dst  = 2'd0;
         end
         bspe_pkg::ST_B0_WAIT: begin
            cmd.knot_rd   = 1'b1;
            cmd.knot_addr = IW'(i_ff + CW'(1));
            cmd.knot_dst  = 2'd1;
         end
         bspe_pkg::ST_B0_CMP: begin
            cmd.b0_write  = 1'b1;
            cmd.b0_closed = (i_ff < CW'(deg_ff) + CW'(1));
         end
         bspe_pkg::ST_D_RD0: begin
            cmd.knot_rd   = 1'b1;
            cmd.knot_addr = sub_ff[0] ? IW'(i_ff + CW'(1)) : IW'(i_ff);
            cmd.knot_dst  = sub_ff[0] ? 2'd2 : 2'd0;
            cmd.basis_rd   = 1'b1;
            cmd.basis_addr = sub_ff[0] ? IW'(i_ff + CW'(1)) : IW'(i_ff);
            cmd.basis_dst  = sub_ff[0];
         end
         bspe_pkg::ST_D_RD1: begin
            cmd.knot_rd   = 1'b1;
            cmd.knot_addr = sub_ff[0] ? IW'(i_ff + CW'(d_ff) + CW'(1)) :
                                        IW'(i_ff + CW'(d_ff));
            cmd.knot_dst  = sub_ff[0] ? 2'd3 : 2'd1;
         end
         bspe_pkg::ST_T0_MUL: cmd.term_mul = 1'b1;
         bspe_pkg::ST_T0_DIV: cmd.div_start = 1'b1;
         bspe_pkg::ST_T0_WAIT: cmd.div_take = stat.div_done;
         bspe_pkg::ST_T1_MUL: begin
            cmd.term_mul = 1'b1;
            cmd.term_sel = 1'b1;
         end
         bspe_pkg::ST_T1_DIV: begin
            cmd.div_start = 1'b1;
            cmd.term_sel  = 1'b1;
         end
         bspe_pkg::ST_T1_WAIT: begin
            cmd.div_take = stat.div_done;
            cmd.term_sel = 1'b1;
         end
         bspe_pkg::ST_D_WR: cmd.basis_wr = 1'b1;
         bspe_pkg::ST_S_RD: begin
            cmd.coeff_rd   = 1'b1;
            cmd.coeff_addr = IW'(i_ff);
            cmd.basis_rd   = 1'b1;
            cmd.basis_addr = IW'(i_ff);
         end
         bspe_pkg::ST_S_MUL: cmd.sum_mul = 1'b1;
         bspe_pkg::ST_S_ACC: cmd.sum_acc = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      deg_ff <= deg_in;
      if (reset) begin
         state_ff <= bspe_pkg::ST_IDLE;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
      end
   end

   assign busy = (state_ff != bspe_pkg::ST_IDLE);
   assign done = (state_ff == bspe_pkg::ST_DONE);

endmodule

### hdl/bspline_point_evaluator_core.sv
// ----------------------------------------------------------------------------
// B-spline point evaluator core
// Cox-de Boor evaluation in signed Q16.16 with knot and coefficient stores.
// ----------------------------------------------------------------------------
// An evaluate beat runs one item at a time: the degree-0 row reads both knots,
// holds and compares for each interval; each basis update then does six store
// reads, two terms (a multiply, then the 65-step pass of the shared divider)
// and a write back, over the sum of n-d-1 updates for d = 1..degree; each output
// term is then read, multiplied and accumulated. The result sits in an output
// register, so the next beat can be accepted while it waits; a finished
// evaluation holds until that register is free.
module bspline_point_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // kind[1:0], slot[6:2], value[38:7], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // spline_value[31:0]
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   logic [bspe_pkg::DEG_W-1:0]  degree_ff;
   logic [bspe_pkg::NCFG_W-1:0] knots_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_data_ff;

   logic [1:0]  kind;
   logic        accept, start, busy, done, rsp_free;
   logic signed [31:0] result;
   bspe_pkg::cmd_type  cmd;
   bspe_pkg::stat_type stat;

   assign kind       = req_tdata[1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && kind == bspe_pkg::KIND_EVAL;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= 3'd3;
         knots_ff     <= 6'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == bspe_pkg::REG_DEGREE) begin
            degree_ff <= csr_wdata[2:0];
         end
         if (csr_wr_en && csr_index == bspe_pkg::REG_KNOTS) begin
            knots_ff <= csr_wdata;
         end
         if (done && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (done && rsp_free) begin
         rsp_data_ff <= result;
      end
   end

   bspe_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .rsp_free (rsp_free),
      .degree   (degree_ff),
      .knots    (knots_ff),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .done     (done)
   );

   bspe_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_kind  (kind),
      .wr_slot  (req_tdata[6:2]),
      .wr_value (req_tdata[38:7]),
      .cmd      (cmd),
      .stat     (stat),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("beat accepted while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result not presented");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("evaluate did not start");
`endif

endmodule

### tb/sv/bspline_point_evaluator_core_test.sv
// ----------------------------------------------------------------------------
// B-spline point evaluator core testbench
// Drives knot, coefficient, evaluate and unused-kind beats with random gaps and result
// stalls, predicts every spline value with its own Cox-de Boor model and
// checks each result beat in order. Several degree and knot count settings
// are swept, extremes included.
// ----------------------------------------------------------------------------
module bspline_point_evaluator_core_test;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int IDLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 20000;

   class spline_scoreboard;
      logic [2:0] degree;
      logic [5:0] knot_count;
      longint knots[bspe_pkg::MAX_KNOTS];
      longint coeffs[bspe_pkg::MAX_KNOTS];
      longint basis[bspe_pkg::MAX_KNOTS];
      logic [31:0] expected_values[$];
      int failures;
      int results_seen;

      function new();
         degree = 3;
         knot_count = 2;
         failures = 0;
         results_seen = 0;
         foreach (knots[i]) begin
            knots[i] = 0;
            coeffs[i] = 0;
            basis[i] = 0;
         end
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void note_reg(logic idx, logic [5:0] val);
         if (idx == bspe_pkg::REG_DEGREE) degree = val[2:0];
         else knot_count = val;
      endfunction

      function logic [31:0] spline_at(longint x);
         longint n, deg, b, den, acc, lo, hi;
         bit closed, in_span;
         n = knot_count;
         deg = degree;
         if (n > bspe_pkg::MAX_KNOTS) n = bspe_pkg::MAX_KNOTS;
         if (deg > bspe_pkg::MAX_DEGREE) deg = bspe_pkg::MAX_DEGREE;
         if (n < deg + 2) return 32'd0;
         for (int i = 0; i < n - 1; i++) begin
            lo = knots[i];
            hi = knots[i+1];
            closed = (i < deg + 1) && (knots[0] == lo);
            in_span = (x <= hi) && (closed ? (x >= lo) : (x > lo));
            basis[i] = in_span ? (64'sd1 <<< bspe_pkg::FRAC_BITS) : 0;
         end
         for (int d = 1; d <= deg; d++) begin
            for (int i = 0; i < n - d - 1; i++) begin
               b = 0;
               den = knots[i+d] - knots[i];
               if (den != 0) b = clip32(((x - knots[i]) * basis[i]) / den);
               den = knots[i+d+1] - knots[i+1];
               if (den != 0) b += clip32(((knots[i+d+1] - x) * basis[i+1]) / den);
               basis[i] = clip32(b);
            end
         end
         acc = 0;
         for (int i = 0; i < n - deg - 1; i++)
            acc += (coeffs[i] * basis[i]) >>> bspe_pkg::FRAC_BITS;
         return 32'(clip32(acc));
      endfunction

      function void note_beat(logic [1:0] kind, logic [4:0] slot, logic [31:0] value);
         case (kind)
            bspe_pkg::KIND_KNOT: knots[slot] = longint'(signed'(value));
            bspe_pkg::KIND_COEFF: coeffs[slot] = longint'(signed'(value));
            bspe_pkg::KIND_EVAL:
               expected_values.push_back(spline_at(longint'(signed'(value))));
            default: ;
         endcase
      endfunction

      function void check_beat(logic [31:0] actual);
         logic [31:0] want;
         results_seen++;
         if (expected_values.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, actual);
            failures++;
         end else begin
            want = expected_values.pop_front();
            if (want !== actual) begin
               $display("%0t: spline_value mismatch, expected %h actual %h",
                        $time, want, actual);
               failures++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // kind[1:0], slot[6:2], value[38:7], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // spline_value[31:0]
   logic        csr_wr_en;
   logic        csr_index;
   logic [5:0]  csr_wdata;

   spline_scoreboard sb = new();
   int idle_cycles;
   bit no_gaps;
   int sent_items;

   bspline_point_evaluator_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side; one long hold-off fills the block
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 16);
         if (sb.results_seen == 12) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_beat(rsp_tdata);
         @(negedge clock);
      end
   end

   task automatic send_beat(logic [1:0] kind, logic [4:0] slot, logic [31:0] value);
      int gap;
      @(negedge clock);
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, value, slot, kind};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(kind, slot, value);
      sent_items++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_values.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [5:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.note_reg(idx, val);
   endtask

   function automatic logic [31:0] pick_point(int n);
      logic [31:0] k;
      k = 32'(sb.knots[$urandom_range(0, n - 1)]);
      case ($urandom_range(0, 7))
         0: return k;
         1: return k + 32'd1;
         2: return k - 32'd1;
         3: return $urandom();
         4: return 32'h7fffffff;
         5: return 32'h80000000;
         default: return k + $urandom_range(0, 32'h30000);
      endcase
   endfunction

   task automatic run_setting(int deg, int ncfg, int evals);
      int n, ncoef;
      int kv[];
      logic [31:0] step;
      write_reg(bspe_pkg::REG_DEGREE, 6'(deg));
      write_reg(bspe_pkg::REG_KNOTS, 6'(ncfg));
      n = (ncfg > bspe_pkg::MAX_KNOTS) ? bspe_pkg::MAX_KNOTS : ncfg;
      if (n < 1) n = 1;
      ncoef = n - deg - 1;
      no_gaps = ($urandom_range(0, 3) == 0);
      kv = new[n];
      if ($urandom_range(0, 4) == 0) begin
         foreach (kv[i]) kv[i] = $urandom();
         kv.sort();
      end else begin
         kv[0] = -$urandom_range(0, 32'h40000);
         for (int i = 1; i < n; i++) begin
            step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h30000);
            kv[i] = kv[i-1] + step;
         end
      end
      foreach (kv[i]) send_beat(bspe_pkg::KIND_KNOT, 5'(i), kv[i]);
      for (int i = 0; i < ncoef; i++) send_beat(bspe_pkg::KIND_COEFF, 5'(i), $urandom());
      for (int e = 0; e < evals; e++) begin
         case ($urandom_range(0, 5))
            0: send_beat(bspe_pkg::KIND_COEFF, 5'($urandom_range(0, 31)), $urandom());
            1: send_beat(KIND_NONE, 5'($urandom()), $urandom());
            2: if (n < bspe_pkg::MAX_KNOTS)
                  send_beat(bspe_pkg::KIND_KNOT, 5'($urandom_range(n, 31)), $urandom());
            default: ;
         endcase
         send_beat(bspe_pkg::KIND_EVAL, 5'($urandom()), pick_point(n));
      end
   endtask

   initial begin
      int deg, ncfg;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      sent_items = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: degree 0 on three knots, extremes of the fields
      write_reg(bspe_pkg::REG_DEGREE, 6'd0);
      write_reg(bspe_pkg::REG_KNOTS, 6'd3);
      send_beat(bspe_pkg::KIND_KNOT, 5'd0, 32'h00000000);
      send_beat(bspe_pkg::KIND_KNOT, 5'd1, 32'h00010000);
      send_beat(bspe_pkg::KIND_KNOT, 5'd2, 32'h00020000);
      send_beat(bspe_pkg::KIND_COEFF, 5'd0, 32'h7fffffff);
      send_beat(bspe_pkg::KIND_COEFF, 5'd1, 32'h80000000);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00000000);
      send_beat(bspe_pkg::KIND_EVAL, 5'd31, 32'h00010000);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00018000);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00020000);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'hffffffff);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h7fffffff);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h80000000);
      send_beat(KIND_NONE, 5'd31, 32'hffffffff);
      send_beat(bspe_pkg::KIND_KNOT, 5'd31, 32'h55555555);
      send_beat(bspe_pkg::KIND_COEFF, 5'd31, 32'haaaaaaaa);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00008000);
      // too few knots
      write_reg(bspe_pkg::REG_DEGREE, 6'd3);
      write_reg(bspe_pkg::REG_KNOTS, 6'd2);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00008000);
      write_reg(bspe_pkg::REG_KNOTS, 6'd0);
      send_beat(bspe_pkg::KIND_EVAL, 5'd0, 32'h00000000);

      // settings sweep: extremes first, then mostly small random ones
      run_setting(7, 32, 4);
      run_setting(0, 2, 6);
      run_setting(3, 63, 4);
      run_setting(7, 8, 6);
      while (sent_items < 240) begin
         deg = $urandom_range(0, 7);
         case ($urandom_range(0, 9))
            0: ncfg = $urandom_range(deg + 2, 32);
            1: ncfg = $urandom_range(0, deg + 1);
            default: ncfg = deg + 2 + $urandom_range(0, 4);
         endcase
         run_setting(deg, ncfg, $urandom_range(4, 8));
      end

      drain();
      if (sb.failures == 0 && sb.expected_values.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
